// ===== rtl/wbps_pkg.sv =====
// Shared types, register indexes and pattern helpers for the byte pattern scanner.
package wbps_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int ADDR_W      = 32;
  localparam int CFG_BYTES   = 16;

  typedef logic [7:0]             byte_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [ADDR_W-1:0]      addr_t;

  localparam cfg_index_t REG_PATTERN_LOW  = 3'd0;
  localparam cfg_index_t REG_PATTERN_HIGH = 3'd1;
  localparam cfg_index_t REG_WILD_MASK    = 3'd2;
  localparam cfg_index_t REG_PATTERN_LEN  = 3'd3;
  localparam cfg_index_t REG_OCCURRENCE   = 3'd4;
  localparam cfg_index_t REG_BASE_ADDR    = 3'd5;

  // Pattern bytes beyond the configured sixteen read as zero.
  function automatic byte_t pattern_byte(input cfg_data_t low, input cfg_data_t high,
                                         input int i);
    byte_t b;
    b = '0;
    if (i < 8) begin
      b = low[8*i +: 8];
    end else if (i < CFG_BYTES) begin
      b = high[8*(i-8) +: 8];
    end
    return b;
  endfunction

  // Pattern bytes beyond the configured sixteen are never wildcards.
  function automatic logic is_wild(input logic [CFG_BYTES-1:0] mask, input int i);
    logic w;
    w = 1'b0;
    if (i < CFG_BYTES) begin
      w = mask[i];
    end
    return w;
  endfunction

endpackage

// ===== rtl/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner: window, compare, match count and result register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    data_byte, last_byte
//   out      output     out_valid / out_stall  found, match_address, match_offset
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low; a byte is captured in the input register and its
// result, if any, is registered in the output register when that stage advances.
// The window compare, match count and offset add all sit between those two registers.
// Reset clears the window, counters and the valid bits of both pipeline registers; no clearing pass.
// A held result stalls the input stage only when a new beat is ready to leave it.
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  wbps_pkg::byte_t     data_byte,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                found,
  output wbps_pkg::addr_t     match_address,
  output wbps_pkg::addr_t     match_offset,
  input  logic                cfg_write,
  input  wbps_pkg::cfg_index_t cfg_index,
  input  wbps_pkg::cfg_data_t  cfg_data
);
  import wbps_pkg::*;

  localparam int LEN_W     = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int WIN_IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  cfg_data_t              pattern_low;
  cfg_data_t              pattern_high;
  logic [CFG_BYTES-1:0]   wild_mask;
  logic [4:0]             pattern_length;
  logic [7:0]             wanted;
  addr_t                  base_address;

  logic                   q_valid;
  byte_t                  q_byte;
  logic                   q_last;

  byte_t                  window      [MAX_PATTERN_BYTES];
  byte_t                  window_next [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic [OFFSET_BITS-1:0] offset_full;
  logic [7:0]             match_count;
  logic [7:0]             match_count_next;
  logic                   search_done;

  logic [LEN_W-1:0]       len_used;
  logic                   window_hit;
  logic                   hit;
  logic                   emit;
  logic                   advance;
  addr_t                  offset_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wild_mask      <= '0;
      pattern_length <= 5'd1;
      wanted         <= 8'd1;
      base_address   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_WILD_MASK:    wild_mask      <= cfg_data[CFG_BYTES-1:0];
        REG_PATTERN_LEN:  pattern_length <= cfg_data[4:0];
        REG_OCCURRENCE:   wanted         <= cfg_data[7:0];
        REG_BASE_ADDR:    base_address   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = q_valid && (!out_valid || !out_stall);
  assign in_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_byte <= data_byte;
      q_last <= last_byte;
    end
  end

  always_comb begin
    if (pattern_length == 5'd0) begin
      len_used = LEN_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN_BYTES) begin
      len_used = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_used = LEN_W'(pattern_length);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
      window_next[k] = window[k+1];
    end
    window_next[MAX_PATTERN_BYTES-1] = q_byte;
  end

  always_comb begin
    int pos;
    window_hit = 1'b1;
    pos = 0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (i < int'(len_used) && !is_wild(wild_mask, i)) begin
        pos = MAX_PATTERN_BYTES - int'(len_used) + i;
        if (window_next[WIN_IDX_W'(pos)] != pattern_byte(pattern_low, pattern_high, i)) begin
          window_hit = 1'b0;
        end
      end
    end
  end

  assign bytes_seen_next  = (bytes_seen != '1) ? bytes_seen + 1'b1 : bytes_seen;
  assign match_count_next = (match_count != 8'hFF) ? match_count + 8'd1 : match_count;
  assign offset_full      = bytes_seen_next - OFFSET_BITS'(len_used);
  assign offset_out       = ADDR_W'(offset_full);

  assign hit  = window_hit && (bytes_seen_next >= OFFSET_BITS'(len_used)) &&
                (match_count_next == wanted);
  assign emit = !search_done && (hit || q_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        window[k] <= '0;
      end
      bytes_seen  <= '0;
      match_count <= '0;
      search_done <= 1'b0;
    end else if (advance) begin
      if (q_last) begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
          window[k] <= '0;
        end
        bytes_seen  <= '0;
        match_count <= '0;
        search_done <= 1'b0;
      end else if (!search_done) begin
        window     <= window_next;
        bytes_seen <= bytes_seen_next;
        if (window_hit && (bytes_seen_next >= OFFSET_BITS'(len_used))) begin
          match_count <= match_count_next;
        end
        search_done <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      found         <= hit;
      match_offset  <= hit ? offset_out : '0;
      match_address <= hit ? base_address + offset_out : '0;
    end
  end

endmodule

// ===== rtl/wbps_checker.sv =====
// Port-level checks for the byte pattern scanner, bound to its top level.
module wbps_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 found,
  input wbps_pkg::addr_t      match_address,
  input wbps_pkg::addr_t      match_offset
);
  import wbps_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) &&
      $stable(match_address) && $stable(match_offset))
    else $error("stalled result beat changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_address == '0 && match_offset == '0)
    else $error("not-found beat carries a non-zero offset or address");

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output is free");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
